// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dwpi_pkg.sv =====
// shared types and constants of the dual wheel pi speed controller
`default_nettype none

package dwpi_pkg;

  localparam int ENCODER_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [2:0] REG_SPEED_LIMIT   = 3'd0;
  localparam logic [2:0] REG_DEFAULT_SPEED = 3'd1;
  localparam logic [2:0] REG_PWM_LIMIT     = 3'd2;
  localparam logic [2:0] REG_PERIOD_MS     = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_MS    = 3'd4;
  localparam logic [2:0] REG_KP_Q16        = 3'd5;
  localparam logic [2:0] REG_KI_Q16        = 3'd6;

  localparam logic [9:0]  RST_SPEED_LIMIT   = 10'd300;
  localparam logic [9:0]  RST_DEFAULT_SPEED = 10'd100;
  localparam logic [14:0] RST_PWM_LIMIT     = 15'd7199;
  localparam logic [15:0] RST_PERIOD_MS     = 16'd100;
  localparam logic [15:0] RST_TIMEOUT_MS    = 16'd500;
  localparam logic [23:0] RST_KP_Q16        = 24'd458752;
  localparam logic [23:0] RST_KI_Q16        = 24'd1049;

  // event codes
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_FORWARD  = 4'd1;
  localparam logic [3:0] EV_BACKWARD = 4'd2;
  localparam logic [3:0] EV_TURN_L   = 4'd3;
  localparam logic [3:0] EV_TURN_R   = 4'd4;
  localparam logic [3:0] EV_SPIN_L   = 4'd5;
  localparam logic [3:0] EV_SPIN_R   = 4'd6;
  localparam logic [3:0] EV_STOP     = 4'd7;
  localparam logic [3:0] EV_UNKNOWN  = 4'd8;
  localparam logic [3:0] EV_TIMEOUT  = 4'd9;
  localparam logic [3:0] EV_IGNORED  = 4'd10;

  // command characters
  localparam logic [7:0] CH_F   = 8'h46;
  localparam logic [7:0] CH_B   = 8'h42;
  localparam logic [7:0] CH_L   = 8'h4C;
  localparam logic [7:0] CH_R   = 8'h52;
  localparam logic [7:0] CH_Q   = 8'h51;
  localparam logic [7:0] CH_E   = 8'h45;
  localparam logic [7:0] CH_S   = 8'h53;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SET,
    ACT_STOP
  } cmd_act_t;

  typedef struct packed {
    cmd_act_t          act;
    logic [3:0]        ev;
    logic signed [10:0] goal_l;
    logic signed [10:0] goal_r;
  } cmd_dec_t;

  typedef struct packed {
    logic signed [15:0] accum;
    logic signed [16:0] err;
  } wheel_upd_t;

endpackage

`default_nettype wire

// ===== rtl/dwpi_cmd_dec.sv =====
// command byte decoder: case folding, goal selection and event code
`default_nettype none

module dwpi_cmd_dec (
  input  wire logic [7:0]        cmd_byte,
  input  wire logic [9:0]        default_speed,
  input  wire logic [9:0]        speed_limit,
  output dwpi_pkg::cmd_dec_t     dec
);
  import dwpi_pkg::*;

  logic [7:0]         ch;
  logic [9:0]         spd;
  logic signed [10:0] pos;
  logic signed [10:0] neg;

  assign spd = (default_speed < speed_limit) ? default_speed : speed_limit;
  assign pos = $signed({1'b0, spd});
  assign neg = -pos;
  assign ch  = ((cmd_byte >= CH_LC_A) && (cmd_byte <= CH_LC_Z)) ? cmd_byte - CASE_OFFSET
                                                                 : cmd_byte;

  always_comb begin
    dec.act    = ACT_STOP;
    dec.ev     = EV_UNKNOWN;
    dec.goal_l = '0;
    dec.goal_r = '0;
    unique case (ch) inside
      CH_F: begin
        dec.act = ACT_SET; dec.ev = EV_FORWARD;  dec.goal_l = pos; dec.goal_r = pos;
      end
      CH_B: begin
        dec.act = ACT_SET; dec.ev = EV_BACKWARD; dec.goal_l = neg; dec.goal_r = neg;
      end
      CH_L: begin
        dec.act = ACT_SET; dec.ev = EV_TURN_L;   dec.goal_r = pos;
      end
      CH_R: begin
        dec.act = ACT_SET; dec.ev = EV_TURN_R;   dec.goal_l = pos;
      end
      CH_Q: begin
        dec.act = ACT_SET; dec.ev = EV_SPIN_L;   dec.goal_l = neg; dec.goal_r = pos;
      end
      CH_E: begin
        dec.act = ACT_SET; dec.ev = EV_SPIN_R;   dec.goal_l = pos; dec.goal_r = neg;
      end
      CH_S: begin
        dec.act = ACT_STOP; dec.ev = EV_STOP;
      end
      CH_NUL, CH_CR, CH_LF: begin
        dec.act = ACT_NONE; dec.ev = EV_IGNORED;
      end
      default: begin
        dec.act = ACT_STOP; dec.ev = EV_UNKNOWN;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dwpi_wheel.sv =====
// incremental pi update for one wheel
`default_nettype none

module dwpi_wheel #(
  parameter int ENCODER_BITS = dwpi_pkg::ENCODER_BITS_DEF
) (
  input  wire logic signed [10:0] goal,
  input  wire logic signed [15:0] speed_raw,
  input  wire logic signed [15:0] accum,
  input  wire logic signed [16:0] prev_err,
  input  wire logic [23:0]        kp_q16,
  input  wire logic [23:0]        ki_q16,
  input  wire logic [14:0]        pwm_limit,
  output dwpi_pkg::wheel_upd_t    upd
);
  import dwpi_pkg::*;

  localparam int SAT_BITS = (ENCODER_BITS < 16) ? ENCODER_BITS : 16;
  localparam logic signed [15:0] SPD_HI = 16'((33'sd1 <<< (SAT_BITS - 1)) - 33'sd1);
  localparam logic signed [15:0] SPD_LO = -SPD_HI - 16'sd1;

  logic signed [15:0] spd;
  logic signed [16:0] err;
  logic signed [17:0] diff;
  logic signed [42:0] p_prod;
  logic signed [42:0] i_prod;
  logic signed [42:0] sum;
  logic               round_up;
  logic signed [26:0] quot;
  logic signed [27:0] acc_new;
  logic signed [27:0] lim;

  always_comb begin
    if (speed_raw > SPD_HI) begin
      spd = SPD_HI;
    end else if (speed_raw < SPD_LO) begin
      spd = SPD_LO;
    end else begin
      spd = speed_raw;
    end
  end

  assign err    = {{6{goal[10]}}, goal} - {spd[15], spd};
  assign diff   = {err[16], err} - {prev_err[16], prev_err};
  assign p_prod = $signed({1'b0, kp_q16}) * diff;
  assign i_prod = $signed({1'b0, ki_q16}) * err;
  assign sum    = p_prod + i_prod;

  // divide by 65536 truncating toward zero
  assign round_up = sum[42] && (sum[15:0] != 16'd0);
  assign quot     = sum[42:16] + $signed({26'd0, round_up});
  assign acc_new  = {{12{accum[15]}}, accum} + {quot[26], quot};
  assign lim      = $signed({13'd0, pwm_limit});

  always_comb begin
    if (acc_new > lim) begin
      upd.accum = lim[15:0];
    end else if (acc_new < -lim) begin
      upd.accum = 16'(-lim);
    end else begin
      upd.accum = acc_new[15:0];
    end
    upd.err = err;
  end

endmodule

`default_nettype wire

// ===== rtl/dual_wheel_pi_speed_controller.sv =====
// top level of the dual wheel pi speed controller
//
// Two-wheel speed controller fed by a stream of command bytes and millisecond
// ticks that carry encoder speeds; every accepted item gives exactly one result
// item with the event code, the control-update flag, both drive values and both
// wheel goals after the item. An item passes an input register and a result
// register, so out_tvalid rises when the item moves on from the input register,
// which happens once the result register is free; one item is taken
// every cycle while the result side keeps up. The per-item path is a 25x18
// multiply for the proportional term and a 25x17 multiply for the integral
// term per wheel, the sum, the correction toward zero and the clamp.
// Configuration writes take effect at once and belong in idle periods.
`default_nettype none
`include "assert_macros.svh"

module dual_wheel_pi_speed_controller #(
  parameter int ENCODER_BITS = dwpi_pkg::ENCODER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // cmd_byte[7:0], enc_l[23:8], enc_r[39:24]
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // left_drive[15:0], right_drive[31:16],
                                       // left_goal[42:32], right_goal[53:43], zero pad
  output logic [4:0]       out_tuser,  // event_res[3:0], control_ran[4]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);
  import dwpi_pkg::*;

  // configuration
  logic [9:0]  speed_limit_r;
  logic [9:0]  default_speed_r;
  logic [14:0] pwm_limit_r;
  logic [15:0] period_ms_r;
  logic [15:0] timeout_ms_r;
  logic [23:0] kp_q16_r;
  logic [23:0] ki_q16_r;

  // input register
  logic               in_v_r;
  logic               func_r;
  logic [7:0]         byte_r;
  logic signed [15:0] lspd_r;
  logic signed [15:0] rspd_r;

  // controller state
  logic signed [10:0] goal_l_r, goal_l_nxt;
  logic signed [10:0] goal_r_r, goal_r_nxt;
  logic signed [15:0] acc_l_r, acc_l_nxt;
  logic signed [15:0] acc_r_r, acc_r_nxt;
  logic signed [16:0] prev_l_r, prev_l_nxt;
  logic signed [16:0] prev_r_r, prev_r_nxt;
  logic [15:0]        period_cnt_r, period_cnt_nxt;
  logic [15:0]        timeout_cnt_r, timeout_cnt_nxt;
  logic               active_r, active_nxt;

  // result register
  logic       out_v_r;
  logic [3:0] ev_r, ev_nxt;
  logic       ran_r, ran_nxt;

  logic        proc;
  logic [15:0] period_inc;
  logic        stop_now;
  cmd_dec_t    dec;
  wheel_upd_t  upd_l;
  wheel_upd_t  upd_r;

  assign proc      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;

  dwpi_cmd_dec u_dec (
    .cmd_byte      (byte_r),
    .default_speed (default_speed_r),
    .speed_limit   (speed_limit_r),
    .dec           (dec)
  );

  dwpi_wheel #(.ENCODER_BITS(ENCODER_BITS)) u_wheel_l (
    .goal      (goal_l_r),
    .speed_raw (lspd_r),
    .accum     (acc_l_r),
    .prev_err  (prev_l_r),
    .kp_q16    (kp_q16_r),
    .ki_q16    (ki_q16_r),
    .pwm_limit (pwm_limit_r),
    .upd       (upd_l)
  );

  dwpi_wheel #(.ENCODER_BITS(ENCODER_BITS)) u_wheel_r (
    .goal      (goal_r_r),
    .speed_raw (rspd_r),
    .accum     (acc_r_r),
    .prev_err  (prev_r_r),
    .kp_q16    (kp_q16_r),
    .ki_q16    (ki_q16_r),
    .pwm_limit (pwm_limit_r),
    .upd       (upd_r)
  );

  assign period_inc = period_cnt_r + 16'd1;
  assign stop_now   = active_r && (timeout_cnt_r >= timeout_ms_r);

  always_comb begin
    goal_l_nxt      = goal_l_r;
    goal_r_nxt      = goal_r_r;
    acc_l_nxt       = acc_l_r;
    acc_r_nxt       = acc_r_r;
    prev_l_nxt      = prev_l_r;
    prev_r_nxt      = prev_r_r;
    period_cnt_nxt  = period_cnt_r;
    timeout_cnt_nxt = timeout_cnt_r;
    active_nxt      = active_r;
    ev_nxt          = EV_NONE;
    ran_nxt         = 1'b0;
    if (!func_r) begin
      ev_nxt = dec.ev;
      case (dec.act)
        ACT_SET: begin
          if ((dec.goal_l != goal_l_r) || (dec.goal_r != goal_r_r)) begin
            acc_l_nxt  = '0;
            acc_r_nxt  = '0;
            prev_l_nxt = '0;
            prev_r_nxt = '0;
          end
          goal_l_nxt      = dec.goal_l;
          goal_r_nxt      = dec.goal_r;
          timeout_cnt_nxt = '0;
          active_nxt      = 1'b1;
        end
        ACT_STOP: begin
          goal_l_nxt      = '0;
          goal_r_nxt      = '0;
          acc_l_nxt       = '0;
          acc_r_nxt       = '0;
          prev_l_nxt      = '0;
          prev_r_nxt      = '0;
          timeout_cnt_nxt = '0;
          active_nxt      = 1'b0;
        end
        default: begin
        end
      endcase
    end else begin
      ran_nxt        = (period_inc >= period_ms_r);
      period_cnt_nxt = ran_nxt ? 16'd0 : period_inc;
      if (stop_now) begin
        ev_nxt          = EV_TIMEOUT;
        goal_l_nxt      = '0;
        goal_r_nxt      = '0;
        acc_l_nxt       = '0;
        acc_r_nxt       = '0;
        prev_l_nxt      = '0;
        prev_r_nxt      = '0;
        timeout_cnt_nxt = '0;
        active_nxt      = 1'b0;
      end else if (active_r) begin
        timeout_cnt_nxt = timeout_cnt_r + 16'd1;
      end
      if (ran_nxt && !stop_now) begin
        if ((goal_l_r == 11'sd0) && (goal_r_r == 11'sd0)) begin
          acc_l_nxt  = '0;
          acc_r_nxt  = '0;
          prev_l_nxt = '0;
          prev_r_nxt = '0;
        end else begin
          acc_l_nxt  = upd_l.accum;
          acc_r_nxt  = upd_r.accum;
          prev_l_nxt = upd_l.err;
          prev_r_nxt = upd_r.err;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r   <= RST_SPEED_LIMIT;
      default_speed_r <= RST_DEFAULT_SPEED;
      pwm_limit_r     <= RST_PWM_LIMIT;
      period_ms_r     <= RST_PERIOD_MS;
      timeout_ms_r    <= RST_TIMEOUT_MS;
      kp_q16_r        <= RST_KP_Q16;
      ki_q16_r        <= RST_KI_Q16;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SPEED_LIMIT:   speed_limit_r   <= cfg_wdata[9:0];
        REG_DEFAULT_SPEED: default_speed_r <= cfg_wdata[9:0];
        REG_PWM_LIMIT:     pwm_limit_r     <= cfg_wdata[14:0];
        REG_PERIOD_MS:     period_ms_r     <= cfg_wdata[15:0];
        REG_TIMEOUT_MS:    timeout_ms_r    <= cfg_wdata[15:0];
        REG_KP_Q16:        kp_q16_r        <= cfg_wdata;
        REG_KI_Q16:        ki_q16_r        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r <= in_tuser;
      byte_r <= in_tdata[7:0];
      lspd_r <= $signed(in_tdata[23:8]);
      rspd_r <= $signed(in_tdata[39:24]);
    end
  end

  // controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_l_r      <= '0;
      goal_r_r      <= '0;
      acc_l_r       <= '0;
      acc_r_r       <= '0;
      prev_l_r      <= '0;
      prev_r_r      <= '0;
      period_cnt_r  <= '0;
      timeout_cnt_r <= '0;
      active_r      <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      if (proc) begin
        goal_l_r      <= goal_l_nxt;
        goal_r_r      <= goal_r_nxt;
        acc_l_r       <= acc_l_nxt;
        acc_r_r       <= acc_r_nxt;
        prev_l_r      <= prev_l_nxt;
        prev_r_r      <= prev_r_nxt;
        period_cnt_r  <= period_cnt_nxt;
        timeout_cnt_r <= timeout_cnt_nxt;
        active_r      <= active_nxt;
        out_v_r       <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      ev_r  <= ev_nxt;
      ran_r <= ran_nxt;
    end
  end

  // drive equals the accumulator after every update
  assign out_tvalid = out_v_r;
  assign out_tuser  = {ran_r, ev_r};
  assign out_tdata  = {2'b00, goal_r_r, goal_l_r, acc_r_r, acc_l_r};

  `ASSERT_IMPL(a_idle_no_timeout, clk, rst_n, !active_r, timeout_cnt_r == 16'd0,
               "timeout counter running without an active command")
  `ASSERT_IMPL(a_idle_goals_zero, clk, rst_n, !active_r,
               (goal_l_r == 11'sd0) && (goal_r_r == 11'sd0),
               "nonzero goal without an active command")
  `ASSERT_NEXT(a_cmd_keeps_period, clk, rst_n, proc && !func_r, $stable(period_cnt_r),
               "command item changed the period counter")
  `ASSERT_NEXT(a_result_after_proc, clk, rst_n, proc, out_tvalid,
               "processed item gave no result")

endmodule

`default_nettype wire

// ===== tb/tb_dual_wheel_pi_speed_controller.sv =====
// self-checking testbench for the dual wheel pi speed controller
module tb_dual_wheel_pi_speed_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import dwpi_pkg::*;

  typedef struct {
    logic [3:0]         ev;
    bit                 ran;
    logic signed [15:0] drv_l;
    logic signed [15:0] drv_r;
    logic signed [10:0] goal_l;
    logic signed [10:0] goal_r;
  } wheel_report_t;

  class speed_loop_scoreboard;
    logic [9:0]         spd_lim;
    logic [9:0]         dflt_spd;
    logic [14:0]        pwm_lim;
    logic [15:0]        period_len;
    logic [15:0]        timeout_len;
    logic [23:0]        kp;
    logic [23:0]        ki;
    logic signed [10:0] goal_l;
    logic signed [10:0] goal_r;
    logic signed [15:0] acc_l;
    logic signed [15:0] acc_r;
    logic signed [15:0] drv_l;
    logic signed [15:0] drv_r;
    logic signed [16:0] perr_l;
    logic signed [16:0] perr_r;
    logic [15:0]        period_cnt;
    logic [15:0]        timeout_cnt;
    bit                 active;
    wheel_report_t      reports_due[$];
    int                 errors;

    function void clear_loop();
      acc_l = 0;
      acc_r = 0;
      perr_l = 0;
      perr_r = 0;
      drv_l = 0;
      drv_r = 0;
    endfunction

    function void halt();
      goal_l = 0;
      goal_r = 0;
      active = 0;
      timeout_cnt = 0;
      clear_loop();
    endfunction

    function void reset_state();
      spd_lim = RST_SPEED_LIMIT;
      dflt_spd = RST_DEFAULT_SPEED;
      pwm_lim = RST_PWM_LIMIT;
      period_len = RST_PERIOD_MS;
      timeout_len = RST_TIMEOUT_MS;
      kp = RST_KP_Q16;
      ki = RST_KI_Q16;
      period_cnt = 0;
      errors = 0;
      halt();
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_SPEED_LIMIT:   spd_lim = val[9:0];
        REG_DEFAULT_SPEED: dflt_spd = val[9:0];
        REG_PWM_LIMIT:     pwm_lim = val[14:0];
        REG_PERIOD_MS:     period_len = val[15:0];
        REG_TIMEOUT_MS:    timeout_len = val[15:0];
        REG_KP_Q16:        kp = val;
        REG_KI_Q16:        ki = val;
        default: ;
      endcase
    endfunction

    function void set_goals(logic signed [10:0] l, logic signed [10:0] r);
      if (l != goal_l || r != goal_r) clear_loop();
      goal_l = l;
      goal_r = r;
      timeout_cnt = 0;
      active = 1;
    endfunction

    function void pi_wheel(input logic signed [10:0] goal, input logic signed [15:0] spd,
                           inout logic signed [15:0] acc, inout logic signed [16:0] perr);
      longint e;
      longint sum;
      longint a;
      longint lim;
      e = longint'(goal) - longint'(spd);
      sum = longint'(kp) * (e - longint'(perr)) + longint'(ki) * e;
      a = longint'(acc) + sum / 65536;
      lim = longint'(pwm_lim);
      if (a > lim) a = lim;
      if (a < -lim) a = -lim;
      acc = a[15:0];
      perr = e[16:0];
    endfunction

    function void note_item(bit tick, logic [7:0] cmd, logic signed [15:0] ls,
                            logic signed [15:0] rs);
      logic [7:0]         c;
      logic signed [10:0] s;
      wheel_report_t      rep;
      rep.ev = EV_NONE;
      rep.ran = 0;
      if (!tick) begin
        c = cmd;
        if (c >= CH_LC_A && c <= CH_LC_Z) c = c - CASE_OFFSET;
        s = $signed({1'b0, (dflt_spd < spd_lim) ? dflt_spd : spd_lim});
        case (c)
          CH_F: begin
            set_goals(s, s);
            rep.ev = EV_FORWARD;
          end
          CH_B: begin
            set_goals(-s, -s);
            rep.ev = EV_BACKWARD;
          end
          CH_L: begin
            set_goals(0, s);
            rep.ev = EV_TURN_L;
          end
          CH_R: begin
            set_goals(s, 0);
            rep.ev = EV_TURN_R;
          end
          CH_Q: begin
            set_goals(-s, s);
            rep.ev = EV_SPIN_L;
          end
          CH_E: begin
            set_goals(s, -s);
            rep.ev = EV_SPIN_R;
          end
          CH_S: begin
            halt();
            rep.ev = EV_STOP;
          end
          CH_NUL, CH_CR, CH_LF: rep.ev = EV_IGNORED;
          default: begin
            halt();
            rep.ev = EV_UNKNOWN;
          end
        endcase
      end else begin
        period_cnt = period_cnt + 16'd1;
        if (period_cnt >= period_len) begin
          period_cnt = 0;
          rep.ran = 1;
        end
        if (active) begin
          if (timeout_cnt < timeout_len) begin
            timeout_cnt = timeout_cnt + 16'd1;
          end else begin
            halt();
            rep.ev = EV_TIMEOUT;
          end
        end
        if (rep.ran) begin
          if (goal_l == 0 && goal_r == 0) begin
            clear_loop();
          end else begin
            pi_wheel(goal_l, ls, acc_l, perr_l);
            pi_wheel(goal_r, rs, acc_r, perr_r);
            drv_l = acc_l;
            drv_r = acc_r;
          end
        end
      end
      rep.drv_l = drv_l;
      rep.drv_r = drv_r;
      rep.goal_l = goal_l;
      rep.goal_r = goal_r;
      reports_due.push_back(rep);
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(logic [4:0] tuser, logic [55:0] tdata);
      wheel_report_t rep;
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result item: expected none actual %h/%h",
                 $time, tuser, tdata);
        return;
      end
      rep = reports_due.pop_front();
      compare("event", longint'(rep.ev), longint'(tuser[3:0]));
      compare("control_ran", longint'(rep.ran), longint'(tuser[4]));
      compare("left_drive", longint'(rep.drv_l), longint'($signed(tdata[15:0])));
      compare("right_drive", longint'(rep.drv_r), longint'($signed(tdata[31:16])));
      compare("left_goal", longint'(rep.goal_l), longint'($signed(tdata[42:32])));
      compare("right_goal", longint'(rep.goal_r), longint'($signed(tdata[53:43])));
      compare("pad", 0, longint'(tdata[55:54]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  bit burst = 0;
  bit hold_req = 0;
  speed_loop_scoreboard sb;

  dual_wheel_pi_speed_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall = 80;
      end else if (stall == 0 && !burst) begin
        stall = idle_len();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tuser, out_tdata);
  end

  task automatic send_item(bit tick, logic [7:0] cmd, logic [15:0] ls, logic [15:0] rs);
    int gap;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= tick;
    in_tdata <= {rs, ls, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_item(tick, cmd, ls, rs);
  endtask

  task automatic send_cmd(logic [7:0] c);
    send_item(1'b0, c, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_tick(logic [15:0] l, logic [15:0] r);
    send_item(1'b1, 8'($urandom), l, r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_config(logic [23:0] sl, logic [23:0] ds, logic [23:0] pwm,
                             logic [23:0] per, logic [23:0] tmo, logic [23:0] p_gain,
                             logic [23:0] i_gain);
    write_reg(REG_SPEED_LIMIT, sl);
    write_reg(REG_DEFAULT_SPEED, ds);
    write_reg(REG_PWM_LIMIT, pwm);
    write_reg(REG_PERIOD_MS, per);
    write_reg(REG_TIMEOUT_MS, tmo);
    write_reg(REG_KP_Q16, p_gain);
    write_reg(REG_KI_Q16, i_gain);
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_config(int per_hi, bit long_period);
    int          r;
    logic [23:0] pwm;
    r = $urandom_range(0, 3);
    if (r == 0) pwm = 1;
    else if (r == 1) pwm = 24'($urandom_range(1, 200));
    else if (r == 2) pwm = 24'(RST_PWM_LIMIT);
    else pwm = 24'($urandom_range(1, 32767));
    load_config(24'($urandom_range(0, 1023)), 24'($urandom_range(0, 1023)), pwm,
                long_period ? 24'd65535 : 24'($urandom_range(0, per_hi)),
                ($urandom_range(0, 9) == 0) ? 24'd65535 : 24'($urandom_range(0, 40)),
                $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 1 << 20)),
                $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 4096)));
  endtask

  function automatic logic [7:0] random_cmd();
    logic [7:0] motion [6];
    logic [7:0] c;
    int         r;
    motion = '{CH_F, CH_B, CH_L, CH_R, CH_Q, CH_E};
    r = $urandom_range(0, 99);
    if (r < 70) c = motion[3'($urandom_range(0, 5))];
    else if (r < 80) c = CH_S;
    else if (r < 83) return CH_NUL;
    else if (r < 86) return CH_CR;
    else if (r < 88) return CH_LF;
    else return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1)) c = c | CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [15:0] wheel_speed(logic signed [10:0] goal);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v = int'(goal) + int'($urandom_range(0, 120)) - 60;
      return v[15:0];
    end
    if (r < 85) return 16'($urandom);
    if (r < 90) return 16'h7FFF;
    if (r < 95) return 16'h8000;
    return 16'h0000;
  endfunction

  task automatic random_item();
    if ($urandom_range(0, 99) < 25)
      send_cmd(random_cmd());
    else
      send_tick(wheel_speed(sb.goal_l), wheel_speed(sb.goal_r));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: widest settings, every command, folding, ignored bytes, timeout
    load_config(1023, 1023, 32767, 1, 3, 24'hFFFFFF, 24'hFFFFFF);
    send_cmd(CH_F);
    send_tick(16'h7FFF, 16'h8000);
    send_tick(16'h8000, 16'h7FFF);
    send_cmd(CH_B | CASE_OFFSET);
    send_tick(16'h0000, 16'h0000);
    send_cmd(CH_L | CASE_OFFSET);
    send_cmd(CH_R);
    send_cmd(CH_Q | CASE_OFFSET);
    send_cmd(CH_E);
    send_cmd(CH_E | CASE_OFFSET);
    send_tick(16'd100, -16'sd100);
    send_tick(16'd1023, -16'sd1023);
    send_tick(16'hFFFF, 16'h0001);
    send_tick(16'h1234, 16'hEDCB);
    send_cmd(CH_S);
    send_cmd(8'h78);
    send_cmd(8'hFF);
    send_cmd(CH_NUL);
    send_cmd(CH_CR);
    send_cmd(CH_LF);
    send_cmd(CH_LC_Z);
    send_cmd(CH_B);
    send_tick(16'h5555, 16'hAAAA);
    send_cmd(CH_LC_A);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_config(0, 0, 0, 0, 0, 0, 0);
        1: load_config(24'(RST_SPEED_LIMIT), 24'(RST_DEFAULT_SPEED), 24'(RST_PWM_LIMIT), 3,
                       24'(RST_TIMEOUT_MS), RST_KP_Q16, RST_KI_Q16);
        2: load_config(1023, 1023, 32767, 1, 65535, 24'hFFFFFF, 24'hFFFFFF);
        6: load_random_config(5, 1'b1);
        default: load_random_config((ph == 4) ? 0 : 5, 1'b0);
      endcase
      burst = (ph == 3 || ph == 5);
      if (ph == 3) hold_req = 1;
      repeat (75) random_item();
      drain();
      burst = 0;
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
